// ===== rtl/ajrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ajrb_pkg
// Shared types and constants of the audio jitter ring buffer.
// ----------------------------------------------------------------------------
package ajrb_pkg;

	// item command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PLAY  = 1'b1;

	// result status codes
	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_REFUSED   = 3'd1,
		ST_STALL_RST = 3'd2,
		ST_DATA      = 3'd3,
		ST_PRIMING   = 3'd4,
		ST_UNDERRUN  = 3'd5,
		ST_UR_RST    = 3'd6
	} status_t;

	// register map
	localparam int          PADDR_W    = 4;
	localparam logic [1:0]  REG_PREBUF = 2'd0;
	localparam logic [1:0]  REG_ULIMIT = 2'd1;
	localparam logic [1:0]  REG_SLIMIT = 2'd2;

	// register reset values
	localparam logic [11:0] PREBUF_RST = 12'd2731;
	localparam logic [7:0]  ULIMIT_RST = 8'd8;
	localparam logic [15:0] SLIMIT_RST = 16'd2000;

	// free slots that must remain after a store
	localparam int          FREE_MARGIN = 4;
	localparam logic [8:0]  SCORE_STEP  = 9'd2;
	localparam logic [8:0]  SCORE_MAX   = 9'd511;

	// job queue between front and back end
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam int ADDR_MAX = 16;

	typedef struct packed {
		logic [11:0] prebuffer_level;
		logic [7:0]  underrun_limit;
		logic [15:0] stall_limit;
	} cfg_t;

	typedef struct packed {
		status_t               st;
		logic                  is_data;
		logic [6:0]            len;
		logic [ADDR_MAX-1:0]   addr;
	} job_t;

endpackage

// ===== rtl/ajrb_if.sv =====
// ----------------------------------------------------------------------------
// ajrb_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ajrb_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;
	logic [6:0] req_len;

	modport source (output valid, cmd, data_byte, req_len, input ready);
	modport sink (input valid, cmd, data_byte, req_len, output ready);
endinterface

interface ajrb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample_byte;
	logic [2:0] status;
	logic       last;

	modport source (output valid, sample_byte, status, last, input ready);
	modport sink (input valid, sample_byte, status, last, output ready);
endinterface

// ===== rtl/ajrb_ram.sv =====
// ----------------------------------------------------------------------------
// ajrb_ram
// Ring store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ajrb_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ajrb_fifo.sv =====
// ----------------------------------------------------------------------------
// ajrb_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ajrb_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ajrb_pkg::job_t   push_data,
	output logic             full,
	input  logic             pop,
	output ajrb_pkg::job_t   pop_data,
	output logic             empty
);

	ajrb_pkg::job_t                     slot_q [ajrb_pkg::QDEPTH];
	logic [ajrb_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [ajrb_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [ajrb_pkg::QCNT_W-1:0]        cnt_q;
	logic                               do_push;
	logic                               do_pop;

	assign full     = (cnt_q == ajrb_pkg::QCNT_W'(ajrb_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ajrb_front.sv =====
// ----------------------------------------------------------------------------
// ajrb_front
// Accepts items, keeps the buffer indices and scores, writes stored bytes
// and turns each item into a job for the back end.
// ----------------------------------------------------------------------------
module ajrb_front #(
	parameter int DEPTH   = 4096,
	parameter int MAX_REQ = 64,
	parameter int AW      = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ajrb_pkg::cfg_t  cfg,
	ajrb_in_if.sink         item_in,
	output logic            push,
	output ajrb_pkg::job_t  push_data,
	input  logic            q_full,
	input  logic            data_done,
	output logic            we,
	output logic [AW-1:0]   waddr,
	output logic [7:0]      wdata
);

	localparam int CW = (AW > 12) ? AW : 12;
	localparam int DW = $clog2(ajrb_pkg::QDEPTH + 2);
	localparam logic [AW-1:0] STORE_LIMIT = AW'(DEPTH - ajrb_pkg::FREE_MARGIN);
	localparam logic [6:0]    REQ_CAP     = 7'(MAX_REQ);

	logic [AW-1:0]  w_q, r_q;
	logic           prim_q;
	logic [8:0]     score_q;
	logic [15:0]    stall_q;
	logic [DW-1:0]  djobs_q;

	logic [AW-1:0]  w_d, r_d;
	logic           prim_d;
	logic [8:0]     score_d;
	logic [15:0]    stall_d;

	logic           accept;
	logic [AW-1:0]  fill;
	logic           can_store;
	logic [15:0]    stall_inc;
	logic           stall_rst;
	logic [6:0]     nsat;
	logic           prime_hold;
	logic           short_fill;
	logic [8:0]     score_add;
	logic           ur_rst;

	// writes wait until no read of stored bytes is outstanding
	assign item_in.ready = !q_full &&
		((item_in.cmd == ajrb_pkg::CMD_PLAY) || (djobs_q == '0));
	assign accept = item_in.valid && item_in.ready;

	// classification
	always_comb begin
		fill       = w_q - r_q;
		can_store  = (fill < STORE_LIMIT);
		stall_inc  = stall_q + 16'd1;
		stall_rst  = (stall_inc >= cfg.stall_limit) || (stall_inc == 16'd0);
		nsat       = (item_in.req_len > REQ_CAP) ? REQ_CAP : item_in.req_len;
		prime_hold = prim_q && (CW'(w_q) < CW'(cfg.prebuffer_level));
		short_fill = (fill <= AW'(nsat));
		score_add  = (score_q > (ajrb_pkg::SCORE_MAX - ajrb_pkg::SCORE_STEP)) ?
			ajrb_pkg::SCORE_MAX : score_q + ajrb_pkg::SCORE_STEP;
		ur_rst     = (score_add > {1'b0, cfg.underrun_limit});
	end

	// next state and job
	always_comb begin
		w_d      = w_q;
		r_d      = r_q;
		prim_d   = prim_q;
		score_d  = score_q;
		stall_d  = stall_q;
		push     = 1'b0;
		push_data.st      = ajrb_pkg::ST_STORED;
		push_data.is_data = 1'b0;
		push_data.len     = 7'd1;
		push_data.addr    = '0;
		we       = 1'b0;
		waddr    = w_q;
		wdata    = item_in.data_byte;
		if (accept) begin
			if (item_in.cmd == ajrb_pkg::CMD_WRITE) begin
				push = 1'b1;
				if (can_store) begin
					we      = 1'b1;
					w_d     = w_q + 1'b1;
					stall_d = '0;
				end else if (stall_rst) begin
					w_d          = '0;
					r_d          = '0;
					score_d      = '0;
					prim_d       = 1'b1;
					stall_d      = '0;
					push_data.st = ajrb_pkg::ST_STALL_RST;
				end else begin
					stall_d      = stall_inc;
					push_data.st = ajrb_pkg::ST_REFUSED;
				end
			end else if (nsat != 7'd0) begin
				push          = 1'b1;
				push_data.len = nsat;
				if (prime_hold) begin
					push_data.st = ajrb_pkg::ST_PRIMING;
				end else begin
					prim_d = 1'b0;
					if (short_fill) begin
						score_d      = score_add;
						push_data.st = ajrb_pkg::ST_UNDERRUN;
						if (ur_rst) begin
							score_d      = '0;
							r_d          = '0;
							w_d          = '0;
							prim_d       = 1'b1;
							push_data.st = ajrb_pkg::ST_UR_RST;
						end
					end else begin
						if (score_q != 9'd0) begin
							score_d = score_q - 9'd1;
						end
						push_data.st      = ajrb_pkg::ST_DATA;
						push_data.is_data = 1'b1;
						push_data.addr    = ajrb_pkg::ADDR_MAX'(r_q);
						r_d               = r_q + AW'(nsat);
					end
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= '0;
			r_q     <= '0;
			prim_q  <= 1'b1;
			score_q <= '0;
			stall_q <= '0;
			djobs_q <= '0;
		end else begin
			w_q     <= w_d;
			r_q     <= r_d;
			prim_q  <= prim_d;
			score_q <= score_d;
			stall_q <= stall_d;
			djobs_q <= djobs_q + DW'(push && push_data.is_data) - DW'(data_done);
		end
	end

endmodule

// ===== rtl/ajrb_back.sv =====
// ----------------------------------------------------------------------------
// ajrb_back
// Expands queued jobs into result items, one per cycle while the output is
// not stalled, reading stored bytes from the ring for data jobs.
// ----------------------------------------------------------------------------
module ajrb_back #(
	parameter int AW = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ajrb_pkg::job_t  pop_data,
	input  logic            q_empty,
	output logic            pop,
	output logic            data_done,
	output logic            re,
	output logic [AW-1:0]   raddr,
	input  logic [7:0]      rdata,
	ajrb_out_if.source      item_out
);

	// current job
	logic                 act_q;
	ajrb_pkg::status_t    st_q;
	logic                 is_data_q;
	logic [6:0]           rem_q;
	logic [AW-1:0]        addr_q;

	// read stage, data arrives from the ring here
	logic                 valid_s1;
	ajrb_pkg::status_t    st_s1;
	logic                 is_data_s1;
	logic                 last_s1;

	// output register
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	ajrb_pkg::status_t    out_st_q;
	logic                 out_last_q;

	logic                 adv_s1;
	logic                 issue;
	logic                 final_beat;

	assign adv_s1     = valid_s1 && (!out_valid_q || item_out.ready);
	assign issue      = act_q && (!valid_s1 || adv_s1);
	assign final_beat = issue && (rem_q == 7'd1);
	assign pop        = !q_empty && (!act_q || final_beat);
	assign data_done  = final_beat && is_data_q;
	assign re         = issue;
	assign raddr      = addr_q;

	assign item_out.valid       = out_valid_q;
	assign item_out.sample_byte = out_byte_q;
	assign item_out.status      = out_st_q;
	assign item_out.last        = out_last_q;

	// job sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (pop) begin
			act_q <= 1'b1;
		end else if (final_beat) begin
			act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			st_q      <= pop_data.st;
			is_data_q <= pop_data.is_data;
			rem_q     <= pop_data.len;
			addr_q    <= pop_data.addr[AW-1:0];
		end else if (issue) begin
			rem_q  <= rem_q - 7'd1;
			addr_q <= addr_q + 1'b1;
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			st_s1      <= st_q;
			is_data_s1 <= is_data_q;
			last_s1    <= (rem_q == 7'd1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (item_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_byte_q <= is_data_s1 ? rdata : 8'd0;
			out_st_q   <= st_s1;
			out_last_q <= last_s1;
		end
	end

endmodule

// ===== rtl/audio_jitter_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// audio_jitter_ring_buffer
// Byte ring buffer between an audio producer and a playout consumer.
// ----------------------------------------------------------------------------
// A write item stores one byte and yields one result; a playout request of
// N bytes (N capped at MAX_REQ, zero gives nothing) yields N results, stored
// bytes or zeros with a status telling why. The front end takes one item per
// cycle unless the queue is full or a write is held off, and hands a job to
// a four-entry queue; the back end emits one result per cycle unless the
// output is stalled. A write item is held off while a request for stored
// bytes is still queued or being read out, since the ring has one write port
// and one read port. A job passes through the job, read-stage and output
// registers. Registers (APB, 32-bit data): 0x0 prebuffer_level, 0x4
// underrun_limit, 0x8 stall_limit; write them only while the block is idle.
// ----------------------------------------------------------------------------
module audio_jitter_ring_buffer #(
	parameter int DEPTH   = 4096,
	parameter int MAX_REQ = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ajrb_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	ajrb_in_if.sink                       item_in,
	ajrb_out_if.source                    item_out
);

	localparam int AW = $clog2(DEPTH);

	ajrb_pkg::cfg_t  cfg_q;
	logic            cfg_wr;
	logic [1:0]      reg_idx;

	logic            push;
	ajrb_pkg::job_t  push_data;
	logic            q_full;
	logic            pop;
	ajrb_pkg::job_t  pop_data;
	logic            q_empty;
	logic            data_done;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [7:0]      wdata;
	logic            re;
	logic [AW-1:0]   raddr;
	logic [7:0]      rdata;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prebuffer_level <= ajrb_pkg::PREBUF_RST;
			cfg_q.underrun_limit  <= ajrb_pkg::ULIMIT_RST;
			cfg_q.stall_limit     <= ajrb_pkg::SLIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				ajrb_pkg::REG_PREBUF: cfg_q.prebuffer_level <= pwdata[11:0];
				ajrb_pkg::REG_ULIMIT: cfg_q.underrun_limit  <= pwdata[7:0];
				ajrb_pkg::REG_SLIMIT: cfg_q.stall_limit     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			ajrb_pkg::REG_PREBUF: prdata = {20'd0, cfg_q.prebuffer_level};
			ajrb_pkg::REG_ULIMIT: prdata = {24'd0, cfg_q.underrun_limit};
			ajrb_pkg::REG_SLIMIT: prdata = {16'd0, cfg_q.stall_limit};
			default:              prdata = 32'd0;
		endcase
	end

	ajrb_front #(
		.DEPTH   (DEPTH),
		.MAX_REQ (MAX_REQ),
		.AW      (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_in   (item_in),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full),
		.data_done (data_done),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata)
	);

	ajrb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	ajrb_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	ajrb_back #(
		.AW (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.q_empty   (q_empty),
		.pop       (pop),
		.data_done (data_done),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata),
		.item_out  (item_out)
	);

endmodule

// ===== test/audio_jitter_ring_buffer_tb.sv =====
// ----------------------------------------------------------------------------
// audio_jitter_ring_buffer_tb
// Self-checking bench for the audio jitter ring buffer.
// ----------------------------------------------------------------------------
// Drives write and playout items through the input channel and keeps a
// software copy of the ring, indices, priming flag, underrun score and stall
// count to predict every output item. Directed tasks cover priming, playout,
// underrun and its reset, and a long output hold-off. Random tasks then run
// under several idling mixes with short prebuffer levels.
// ----------------------------------------------------------------------------
module audio_jitter_ring_buffer_tb;

	localparam int RING_DEPTH   = 4096;
	localparam int MAX_LEN      = 64;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [7:0]          sample;
		ajrb_pkg::status_t   st;
		logic                last;
	} playout_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ajrb_pkg::PADDR_W-1:0]  paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;

	ajrb_in_if  in_ch ();
	ajrb_out_if out_ch ();

	audio_jitter_ring_buffer #(
		.DEPTH   (RING_DEPTH),
		.MAX_REQ (MAX_LEN)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.item_in  (in_ch),
		.item_out (out_ch)
	);

	// software copy of the buffer
	logic [7:0]  ring_copy [RING_DEPTH];
	logic [11:0] wr_ptr = '0;
	logic [11:0] rd_ptr = '0;
	logic        in_priming = 1'b1;
	logic [8:0]  ur_score = '0;
	logic [15:0] stall_cnt = '0;
	logic [11:0] cfg_prebuf = ajrb_pkg::PREBUF_RST;
	logic [7:0]  cfg_ulimit = ajrb_pkg::ULIMIT_RST;
	logic [15:0] cfg_slimit = ajrb_pkg::SLIMIT_RST;

	playout_t    due_samples [$];
	int          n_errors = 0;
	int          n_items = 0;
	int          n_results = 0;
	logic [7:0]  seen_status = '0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_left = 0;

	always #5 clk = ~clk;

	// safety net against a hang
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int ring_fill();
		logic [11:0] d;
		d = wr_ptr - rd_ptr;
		return int'(d);
	endfunction

	function automatic void push_due(input logic [7:0] s, input ajrb_pkg::status_t st,
			input logic lst);
		playout_t p;
		p.sample = s;
		p.st     = st;
		p.last   = lst;
		due_samples.push_back(p);
	endfunction

	function automatic void clear_ring();
		wr_ptr     = '0;
		rd_ptr     = '0;
		ur_score   = '0;
		in_priming = 1'b1;
	endfunction

	// work out the output items of one accepted item
	function automatic void predict_item(input logic c, input logic [7:0] b,
			input logic [6:0] len);
		int                  n;
		int                  fill;
		int                  s;
		int                  i;
		ajrb_pkg::status_t   st;
		logic [11:0]         a;
		fill = ring_fill();
		if (c == ajrb_pkg::CMD_WRITE) begin
			if (RING_DEPTH - fill > ajrb_pkg::FREE_MARGIN) begin
				ring_copy[wr_ptr] = b;
				wr_ptr = wr_ptr + 1'b1;
				stall_cnt = '0;
				st = ajrb_pkg::ST_STORED;
			end else begin
				stall_cnt = stall_cnt + 1'b1;
				if (stall_cnt >= cfg_slimit || stall_cnt == '0) begin
					clear_ring();
					stall_cnt = '0;
					st = ajrb_pkg::ST_STALL_RST;
				end else begin
					st = ajrb_pkg::ST_REFUSED;
				end
			end
			push_due(8'h00, st, 1'b1);
			return;
		end
		n = (int'(len) > MAX_LEN) ? MAX_LEN : int'(len);
		if (n == 0)
			return;
		// silence until the write index reaches the prebuffer level
		if (in_priming) begin
			if (wr_ptr < cfg_prebuf) begin
				for (i = 0; i < n; i++)
					push_due(8'h00, ajrb_pkg::ST_PRIMING, i == n - 1);
				return;
			end
			in_priming = 1'b0;
		end
		// underrun: not more stored than asked for
		if (fill <= n) begin
			s = int'(ur_score) + int'(ajrb_pkg::SCORE_STEP);
			if (s > int'(ajrb_pkg::SCORE_MAX))
				s = int'(ajrb_pkg::SCORE_MAX);
			ur_score = 9'(s);
			st = ajrb_pkg::ST_UNDERRUN;
			if (ur_score > cfg_ulimit) begin
				clear_ring();
				st = ajrb_pkg::ST_UR_RST;
			end
			for (i = 0; i < n; i++)
				push_due(8'h00, st, i == n - 1);
			return;
		end
		// stored bytes
		if (ur_score != '0)
			ur_score = ur_score - 1'b1;
		for (i = 0; i < n; i++) begin
			a = rd_ptr + 12'(i);
			push_due(ring_copy[a], ajrb_pkg::ST_DATA, i == n - 1);
		end
		rd_ptr = rd_ptr + 12'(n);
	endfunction

	// output side: check each item and pick the next ready value
	always @(posedge clk) begin : result_check
		playout_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (due_samples.size() == 0) begin
				$error("unexpected result: sample_byte %0d status %0d last %0d",
					out_ch.sample_byte, out_ch.status, out_ch.last);
				n_errors++;
			end else begin
				want = due_samples.pop_front();
				n_results++;
				seen_status[out_ch.status] = 1'b1;
				if (out_ch.sample_byte !== want.sample) begin
					$error("sample_byte mismatch: expected %0d, actual %0d",
						want.sample, out_ch.sample_byte);
					n_errors++;
				end
				if (out_ch.status !== want.st) begin
					$error("status mismatch: expected %0d, actual %0d",
						want.st, out_ch.status);
					n_errors++;
				end
				if (out_ch.last !== want.last) begin
					$error("last mismatch: expected %0d, actual %0d",
						want.last, out_ch.last);
					n_errors++;
				end
			end
		end
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// offer one item and wait until it is taken
	task automatic send_item(input logic c, input logic [7:0] b, input logic [6:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.cmd       <= c;
		in_ch.data_byte <= b;
		in_ch.req_len   <= len;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_item(c, b, len);
		n_items++;
	endtask

	task automatic write_byte(input logic [7:0] b);
		send_item(ajrb_pkg::CMD_WRITE, b, 7'($urandom_range(127)));
	endtask

	task automatic play(input logic [6:0] len);
		send_item(ajrb_pkg::CMD_PLAY, 8'($urandom_range(255)), len);
	endtask

	// stop sending and let every owed item come out
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (due_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] value);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_idx)
			ajrb_pkg::REG_PREBUF: cfg_prebuf = value[11:0];
			ajrb_pkg::REG_ULIMIT: cfg_ulimit = value[7:0];
			ajrb_pkg::REG_SLIMIT: cfg_slimit = value[15:0];
			default: ;
		endcase
	endtask

	task automatic prime_ring();
		while (in_priming && wr_ptr < cfg_prebuf)
			write_byte(8'($urandom_range(255)));
	endtask

	task automatic drain_low();
		while (ring_fill() > MAX_LEN && !in_priming)
			play(7'(MAX_LEN));
	endtask

	// requests before the prebuffer level give silence
	task automatic test_priming();
		write_byte(8'h00);
		write_byte(8'hFF);
		write_byte(8'h5A);
		write_byte(8'hA5);
		play(7'd1);
		play(7'd64);
		play(7'd0);
		play(7'd127);
		play(7'd65);
		play(7'd100);
		wait_drained();
	endtask

	// playout of stored bytes, length limits and the underrun boundary
	task automatic test_playout();
		cfg_write(ajrb_pkg::REG_PREBUF, 32'd80);
		cfg_write(ajrb_pkg::REG_ULIMIT, 32'd255);
		prime_ring();
		play(7'd1);
		play(7'd64);
		play(7'd127);
		play(7'd0);
		write_byte(8'h00);
		write_byte(8'hFF);
		play(7'd65);
		drain_low();
		repeat (3) write_byte(8'($urandom_range(255)));
		// fill equal to length is an underrun, one less is data
		play(7'(ring_fill()));
		play(7'(ring_fill()));
		play(7'(ring_fill() - 1));
		wait_drained();
	endtask

	// long output hold-off while the sender keeps offering
	task automatic test_backpressure();
		repeat (20) write_byte(8'($urandom_range(255)));
		hold_left = 400;
		repeat (12) begin
			play(7'($urandom_range(16, 1)));
			write_byte(8'($urandom_range(255)));
		end
		wait_drained();
	endtask

	// a zero limit sends the first underrun straight back to priming
	task automatic test_underrun_reset();
		cfg_write(ajrb_pkg::REG_ULIMIT, 32'd0);
		drain_low();
		play(7'd64);
		play(7'd4);
		write_byte(8'h3C);
		play(7'd2);
		wait_drained();
	endtask

	// random mix after priming under one idling setting
	task automatic test_random(input int idle_in, input int stall_out, input int count);
		int r;
		send_idle_pct  = idle_in;
		recv_stall_pct = stall_out;
		cfg_write(ajrb_pkg::REG_PREBUF, $urandom_range(32, 8));
		cfg_write(ajrb_pkg::REG_ULIMIT, $urandom_range(255, 4));
		cfg_write(ajrb_pkg::REG_SLIMIT, $urandom_range(65535, 1));
		prime_ring();
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 55)
				write_byte(8'($urandom_range(255)));
			else if (r < 80)
				play(7'($urandom_range(8, 1)));
			else if (r < 93)
				play(7'($urandom_range(64, 9)));
			else if (r < 96)
				play(7'd0);
			else
				play(7'($urandom_range(127, 65)));
		end
		wait_drained();
	endtask

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_ch.valid     = 1'b0;
		in_ch.cmd       = ajrb_pkg::CMD_WRITE;
		in_ch.data_byte = '0;
		in_ch.req_len   = '0;
		out_ch.ready    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_priming();
		test_playout();
		test_backpressure();
		test_underrun_reset();
		test_random(0, 0, 28);
		test_random(81, 0, 28);
		test_random(0, 81, 28);
		test_random(10, 10, 28);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("covered %0d items and %0d checked results over four idling mixes",
			n_items, n_results);
		$display("status codes seen (bit per code): %b", seen_status[6:0]);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ajrb_pkg.sv
rtl/ajrb_if.sv
rtl/ajrb_ram.sv
rtl/ajrb_fifo.sv
rtl/ajrb_front.sv
rtl/ajrb_back.sv
rtl/audio_jitter_ring_buffer.sv
test/audio_jitter_ring_buffer_tb.sv
